// ----- sv/apsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsc_pkg
// Shared codes and control types of the adaptive supersample controller.
// ----------------------------------------------------------------------------
package apsc_pkg;

    // Input item operations
    typedef enum logic [1:0] {
        OP_RESTART  = 2'd0,
        OP_REQUEST  = 2'd1,
        OP_SAMPLE   = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_START  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_END    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_START  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_END    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LOG2 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LOG2 = 3'd5;

    localparam int unsigned LOG2_BITS = 3;
    localparam logic [LOG2_BITS-1:0] MIN_LOG2_RESET = 3'd2;
    localparam logic [LOG2_BITS-1:0] MAX_LOG2_RESET = 3'd5;

    // Result kinds
    localparam logic KIND_BATCH   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Accumulator control from the decoder
    typedef struct packed {
        logic clear;   // restart or request: start a fresh batch
        logic sample;  // fold one luminance sample in
        logic last;    // sample closes the batch
    } acc_ctl_t;

endpackage

// ----- sv/apsc_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsc_accum
// Luminance sum, minimum and maximum, and the contrast test on the batch.
// ----------------------------------------------------------------------------
module apsc_accum #(
    parameter int unsigned LUM_BITS         = 16,
    parameter int unsigned MAX_SAMPLES_LOG2 = 6,
    parameter int unsigned LG_W             = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  apsc_pkg::acc_ctl_t  ctl,
    input  logic [LUM_BITS-1:0] lum,
    input  logic [LG_W-1:0]     min_lg,
    output logic                needs_more
);
    localparam int unsigned SUM_BITS = LUM_BITS + MAX_SAMPLES_LOG2;
    localparam int unsigned TW       = SUM_BITS + 2;

    logic [SUM_BITS-1:0] sum_reg, sum_next, sum_upd;
    logic [LUM_BITS-1:0] min_reg, min_next, min_upd;
    logic [LUM_BITS-1:0] max_reg, max_next, max_upd;
    logic [SUM_BITS:0]   sum_add;
    logic [TW-1:0]       s, hi, lo;

    assign sum_add = {1'b0, sum_reg} + (SUM_BITS+1)'(lum);
    assign sum_upd = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
    assign min_upd = (lum < min_reg) ? lum : min_reg;
    assign max_upd = (lum > max_reg) ? lum : max_reg;

    // N*L is a shift since N is a power of two
    assign s  = TW'(sum_upd);
    assign hi = TW'(max_upd) << min_lg;
    assign lo = TW'(min_upd) << min_lg;

    always_comb begin
        needs_more = 1'b0;
        if (s != '0) begin
            if (hi > s && ((hi - s) << 1) > s) needs_more = 1'b1;
            if (s > lo && ((s - lo) << 1) > s) needs_more = 1'b1;
        end
    end

    always_comb begin
        sum_next = sum_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (ctl.clear || (ctl.sample && ctl.last)) begin
            sum_next = '0;
            min_next = '1;
            max_next = '0;
        end else if (ctl.sample) begin
            sum_next = sum_upd;
            min_next = min_upd;
            max_next = max_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

// ----- sv/apsc_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsc_walker
// Raster position, supersample mode and result formation.
// ----------------------------------------------------------------------------
module apsc_walker #(
    parameter int unsigned CB    = 13,
    parameter int unsigned CNT_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             go,
    input  apsc_pkg::op_t    op,
    input  logic             last,
    input  logic             needs_more,
    input  logic [CB-1:0]    x_start,
    input  logic [CB-1:0]    x_end,
    input  logic [CB-1:0]    y_start,
    input  logic [CB-1:0]    y_end,
    input  logic [CNT_W-1:0] cnt_min,
    input  logic [CNT_W-1:0] cnt_max,
    output logic             res_valid,
    output logic             res_kind,
    output logic [CB-1:0]    res_x,
    output logic [CB-1:0]    res_y,
    output logic [CNT_W-1:0] res_count,
    output logic             res_done
);
    logic [CB-1:0] x_reg, x_next, y_reg, y_next, x_inc;
    logic          super_reg, super_next;

    assign x_inc = x_reg + 1'b1;
    assign res_x = x_reg;
    assign res_y = y_reg;

    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        super_next = super_reg;
        res_valid  = 1'b0;
        res_kind   = apsc_pkg::KIND_BATCH;
        res_count  = '0;
        res_done   = 1'b0;
        unique case (op)
            apsc_pkg::OP_RESTART: begin
                x_next     = x_start;
                y_next     = y_start;
                super_next = 1'b0;
            end
            apsc_pkg::OP_REQUEST: begin
                res_valid = 1'b1;
                if (super_reg)          res_count = cnt_max;
                else if (y_reg == y_end) res_count = '0;
                else                    res_count = cnt_min;
            end
            apsc_pkg::OP_SAMPLE: begin
                if (last) begin
                    res_valid = 1'b1;
                    res_kind  = apsc_pkg::KIND_VERDICT;
                    if (super_reg) begin
                        super_next = 1'b0;
                        res_done   = 1'b1;
                    end else if (needs_more) begin
                        super_next = 1'b1;
                    end else begin
                        res_done = 1'b1;
                    end
                    if (res_done) begin
                        if (x_inc == x_end) begin
                            x_next = x_start;
                            y_next = y_reg + 1'b1;
                        end else begin
                            x_next = x_inc;
                        end
                    end
                end
            end
            apsc_pkg::OP_RESERVED: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg     <= '0;
            y_reg     <= '0;
            super_reg <= 1'b0;
        end else if (go) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            super_reg <= super_next;
        end
    end

endmodule

// ----- sv/adaptive_pixel_supersample_control.sv -----
`timescale 1ns / 1ps
// Each item passes the input register, then its result the output register.
// Throughput: one item per cycle unless the output stalls; the sum/min/max
//   update and contrast test form one stage between input and output registers.
// Reset (aresetn low, synchronous): config registers to their reset values,
//   position and mode to zero, accumulators cleared. No clearing pass.
// ----------------------------------------------------------------------------
// adaptive_pixel_supersample_control
// Walks a pixel window and decides per pixel whether to supersample, using
// a contrast test on streamed luminance samples.
// ----------------------------------------------------------------------------
module adaptive_pixel_supersample_control #(
    parameter int unsigned COORD_BITS       = 12,
    parameter int unsigned MAX_SAMPLES_LOG2 = 6,
    parameter int unsigned LUM_BITS         = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // config write port
    input  logic                                   cfg_wr_en,
    input  logic [apsc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [COORD_BITS:0]                    cfg_data,
    // input items
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_operation,
    input  logic [LUM_BITS-1:0]                    s_luminance,
    input  logic                                   s_last_sample,
    // result items
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_result_kind,
    output logic [COORD_BITS:0]                    m_pixel_x,
    output logic [COORD_BITS:0]                    m_pixel_y,
    output logic [MAX_SAMPLES_LOG2:0]              m_sample_count,
    output logic                                   m_pixel_done
);
    // Coordinates carry one bit above COORD_BITS so that 2^COORD_BITS fits.
    localparam int unsigned CB    = COORD_BITS + 1;
    localparam int unsigned CNT_W = MAX_SAMPLES_LOG2 + 1;
    localparam int unsigned LG_W  = $clog2(MAX_SAMPLES_LOG2 + 1);

    // ---------------- configuration registers ----------------
    logic [CB-1:0] x_start_reg, x_end_reg, y_start_reg, y_end_reg;
    logic [apsc_pkg::LOG2_BITS-1:0] min_log2_reg, max_log2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_start_reg  <= '0;
            x_end_reg    <= '0;
            y_start_reg  <= '0;
            y_end_reg    <= '0;
            min_log2_reg <= apsc_pkg::MIN_LOG2_RESET;
            max_log2_reg <= apsc_pkg::MAX_LOG2_RESET;
        end else if (cfg_wr_en) begin
            // indexes past the list are dropped
            unique case (cfg_index)
                apsc_pkg::CFG_X_START:  x_start_reg  <= cfg_data;
                apsc_pkg::CFG_X_END:    x_end_reg    <= cfg_data;
                apsc_pkg::CFG_Y_START:  y_start_reg  <= cfg_data;
                apsc_pkg::CFG_Y_END:    y_end_reg    <= cfg_data;
                apsc_pkg::CFG_MIN_LOG2: min_log2_reg <= cfg_data[apsc_pkg::LOG2_BITS-1:0];
                apsc_pkg::CFG_MAX_LOG2: max_log2_reg <= cfg_data[apsc_pkg::LOG2_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Log2 settings saturate at the largest supported sample count.
    logic [LG_W-1:0]  min_lg, max_lg;
    logic [CNT_W-1:0] cnt_min, cnt_max;

    always_comb begin
        if (32'(min_log2_reg) > MAX_SAMPLES_LOG2) min_lg = LG_W'(MAX_SAMPLES_LOG2);
        else                                      min_lg = LG_W'(min_log2_reg);
        if (32'(max_log2_reg) > MAX_SAMPLES_LOG2) max_lg = LG_W'(MAX_SAMPLES_LOG2);
        else                                      max_lg = LG_W'(max_log2_reg);
    end

    assign cnt_min = CNT_W'(1) << min_lg;
    assign cnt_max = CNT_W'(1) << max_lg;

    // ---------------- input register ----------------
    logic                in_vld_reg;
    apsc_pkg::op_t       op_reg;
    logic [LUM_BITS-1:0] lum_reg;
    logic                last_reg;
    logic                out_vld_reg;
    logic                stage_go;

    // The stage fires when it holds an item and the output register is empty or
    // draining, so an item can enter while a result still waits to be taken.
    assign stage_go = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready  = !in_vld_reg || stage_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= apsc_pkg::op_t'(s_operation);
            lum_reg  <= s_luminance;
            last_reg <= s_last_sample;
        end
    end

    // ---------------- processing stage ----------------
    apsc_pkg::acc_ctl_t acc_ctl;
    logic               needs_more;

    assign acc_ctl.clear  = stage_go &&
                            (op_reg == apsc_pkg::OP_RESTART || op_reg == apsc_pkg::OP_REQUEST);
    assign acc_ctl.sample = stage_go && (op_reg == apsc_pkg::OP_SAMPLE);
    assign acc_ctl.last   = last_reg;

    apsc_accum #(
        .LUM_BITS         (LUM_BITS),
        .MAX_SAMPLES_LOG2 (MAX_SAMPLES_LOG2),
        .LG_W             (LG_W)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (acc_ctl),
        .lum        (lum_reg),
        .min_lg     (min_lg),
        .needs_more (needs_more)
    );

    logic             res_valid, res_kind, res_done;
    logic [CB-1:0]    res_x, res_y;
    logic [CNT_W-1:0] res_count;

    apsc_walker #(
        .CB    (CB),
        .CNT_W (CNT_W)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .go         (stage_go),
        .op         (op_reg),
        .last       (last_reg),
        .needs_more (needs_more),
        .x_start    (x_start_reg),
        .x_end      (x_end_reg),
        .y_start    (y_start_reg),
        .y_end      (y_end_reg),
        .cnt_min    (cnt_min),
        .cnt_max    (cnt_max),
        .res_valid  (res_valid),
        .res_kind   (res_kind),
        .res_x      (res_x),
        .res_y      (res_y),
        .res_count  (res_count),
        .res_done   (res_done)
    );

    // ---------------- output register ----------------
    logic             kind_reg, done_reg;
    logic [CB-1:0]    px_reg, py_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (stage_go) begin
            out_vld_reg <= res_valid;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_go && res_valid) begin
            kind_reg  <= res_kind;
            px_reg    <= res_x;
            py_reg    <= res_y;
            count_reg <= res_count;
            done_reg  <= res_done;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_result_kind  = kind_reg;
    assign m_pixel_x      = px_reg;
    assign m_pixel_y      = py_reg;
    assign m_sample_count = count_reg;
    assign m_pixel_done   = done_reg;

    // ---------------- assertions ----------------
    // verdicts never carry a sample count
    a_verdict_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == apsc_pkg::KIND_VERDICT |-> m_sample_count == '0)
        else $error("verdict with nonzero sample count");

    // batch answers never mark the pixel done
    a_batch_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == apsc_pkg::KIND_BATCH |-> !m_pixel_done)
        else $error("batch answer with pixel_done set");

    // a held result blocks the stage
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_ready |-> !stage_go)
        else $error("stage fired over a stalled result");

    // input side backs off only while an item is held
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld_reg && out_vld_reg && !m_ready)
        else $error("input stalled without cause");

endmodule

// ----- tb/adaptive_pixel_supersample_control_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_pixel_supersample_control_test
// Self-checking bench for the adaptive supersample controller. A behavioral
// copy of the window walk, batch accumulators and contrast test predicts every
// batch answer and pixel verdict; a monitor compares each result item, field
// by field, against the oldest prediction. Directed checks come first, then
// randomized windows with mostly well-formed request/sample sequences, random
// idling on both sides, a long output hold-off and a stretch with no idling.
// ----------------------------------------------------------------------------
module adaptive_pixel_supersample_control_test;

    localparam int COORD_BITS       = 12;
    localparam int MAX_SAMPLES_LOG2 = 6;
    localparam int LUM_BITS         = 16;
    localparam int SUM_BITS         = LUM_BITS + MAX_SAMPLES_LOG2;

    localparam int ITEM_TARGET   = 1950;   // stimulus stops after this many items
    localparam int STALL_LIMIT   = 3000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES   = 300;    // receiver hold-off in the pressure test
    localparam int NORMAL_IDLE   = 11;     // percent of idle cycles per side

    // One result item as the block should present it
    typedef struct {
        logic                      kind;
        logic [COORD_BITS:0]       px;
        logic [COORD_BITS:0]       py;
        logic [MAX_SAMPLES_LOG2:0] cnt;
        logic                      done;
    } pixel_result_t;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [apsc_pkg::CFG_IDX_BITS-1:0]   cfg_index;
    logic [COORD_BITS:0]                 cfg_data;
    logic                                s_valid;
    logic                                s_ready;
    logic [1:0]                          s_operation;
    logic [LUM_BITS-1:0]                 s_luminance;
    logic                                s_last_sample;
    logic                                m_valid;
    logic                                m_ready;
    logic                                m_result_kind;
    logic [COORD_BITS:0]                 m_pixel_x;
    logic [COORD_BITS:0]                 m_pixel_y;
    logic [MAX_SAMPLES_LOG2:0]           m_sample_count;
    logic                                m_pixel_done;

    adaptive_pixel_supersample_control #(
        .COORD_BITS      (COORD_BITS),
        .MAX_SAMPLES_LOG2(MAX_SAMPLES_LOG2),
        .LUM_BITS        (LUM_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_luminance   (s_luminance),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_sample_count(m_sample_count),
        .m_pixel_done  (m_pixel_done)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    pixel_result_t due_results[$];    // predicted results, oldest first
    int            fail_count  = 0;
    int            items_sent  = 0;   // op 3 items are not counted
    int            idle_pct    = NORMAL_IDLE;
    int            rx_hold_req = 0;   // set by a test, taken over by the receiver
    int            rx_hold_left = 0;
    int            stall_cycles = 0;
    logic [MAX_SAMPLES_LOG2:0] batch_count_seen;  // count of the latest request

    // Shadow of the configuration registers
    logic [COORD_BITS:0] win_x_start, win_x_end, win_y_start, win_y_end;
    logic [2:0]          win_min_log2, win_max_log2;

    // Shadow of the walk position, mode and batch accumulators
    logic [COORD_BITS:0] walk_x, walk_y;
    logic                refine_pending;
    logic [SUM_BITS-1:0] acc_sum;
    logic [LUM_BITS-1:0] acc_min, acc_max;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // log2 values above the block's maximum saturate
    function automatic logic [MAX_SAMPLES_LOG2:0] samples_for(input logic [2:0] lg);
        if (lg > MAX_SAMPLES_LOG2)
            return 7'd64;
        return 7'(1 << lg);
    endfunction

    function automatic void empty_accumulators();
        acc_sum = '0;
        acc_min = '1;
        acc_max = '0;
    endfunction

    function automatic void reset_walk();
        win_x_start    = '0;
        win_x_end      = '0;
        win_y_start    = '0;
        win_y_end      = '0;
        win_min_log2   = apsc_pkg::MIN_LOG2_RESET;
        win_max_log2   = apsc_pkg::MAX_LOG2_RESET;
        walk_x         = '0;
        walk_y         = '0;
        refine_pending = 1'b0;
        empty_accumulators();
    endfunction

    // Applies one accepted item to the shadow state and queues its result.
    function automatic void step_pixel_walk(input apsc_pkg::op_t op,
                                            input logic [LUM_BITS-1:0] lum,
                                            input logic last);
        pixel_result_t     r;
        logic [SUM_BITS:0] sum_ext;
        longint unsigned   n, s, hi, lo;
        bit                contrast;
        case (op)
            apsc_pkg::OP_RESTART: begin
                walk_x         = win_x_start;
                walk_y         = win_y_start;
                refine_pending = 1'b0;
                empty_accumulators();
            end
            apsc_pkg::OP_REQUEST: begin
                r.kind = apsc_pkg::KIND_BATCH;
                r.px   = walk_x;
                r.py   = walk_y;
                r.done = 1'b0;
                if (refine_pending)
                    r.cnt = samples_for(win_max_log2);
                else if (walk_y == win_y_end)
                    r.cnt = '0;     // window finished
                else
                    r.cnt = samples_for(win_min_log2);
                batch_count_seen = r.cnt;
                empty_accumulators();
                due_results.push_back(r);
            end
            apsc_pkg::OP_SAMPLE: begin
                sum_ext = {1'b0, acc_sum} + lum;
                acc_sum = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
                if (lum < acc_min) acc_min = lum;
                if (lum > acc_max) acc_max = lum;
                if (last) begin
                    // Contrast test against N = 2^min_log2, whatever the batch size
                    n  = samples_for(win_min_log2);
                    s  = acc_sum;
                    hi = n * acc_max;
                    lo = n * acc_min;
                    contrast = (s != 0) &&
                               ((hi > s && 2 * (hi - s) > s) || (s > lo && 2 * (s - lo) > s));
                    r.kind = apsc_pkg::KIND_VERDICT;
                    r.px   = walk_x;
                    r.py   = walk_y;
                    r.cnt  = '0;
                    if (refine_pending) begin
                        refine_pending = 1'b0;
                        r.done = 1'b1;
                    end else if (contrast) begin
                        refine_pending = 1'b1;
                        r.done = 1'b0;
                    end else begin
                        r.done = 1'b1;
                    end
                    if (r.done) begin
                        walk_x = walk_x + 1'b1;
                        if (walk_x == win_x_end) begin
                            walk_x = win_x_start;
                            walk_y = walk_y + 1'b1;
                        end
                    end
                    empty_accumulators();
                    due_results.push_back(r);
                end
            end
            default: ;  // reserved op: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        pixel_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result item: kind %0d x %0d y %0d count %0d done %0d",
                       m_result_kind, m_pixel_x, m_pixel_y, m_sample_count, m_pixel_done);
                fail_count++;
            end else begin
                e = due_results.pop_front();
                if (m_result_kind !== e.kind) begin
                    $error("result_kind: expected %0d, got %0d", e.kind, m_result_kind);
                    fail_count++;
                end
                if (m_pixel_x !== e.px) begin
                    $error("pixel_x: expected %0d, got %0d", e.px, m_pixel_x);
                    fail_count++;
                end
                if (m_pixel_y !== e.py) begin
                    $error("pixel_y: expected %0d, got %0d", e.py, m_pixel_y);
                    fail_count++;
                end
                if (m_sample_count !== e.cnt) begin
                    $error("sample_count: expected %0d, got %0d", e.cnt, m_sample_count);
                    fail_count++;
                end
                if (m_pixel_done !== e.done) begin
                    $error("pixel_done: expected %0d, got %0d", e.done, m_pixel_done);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no item moves on either side for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[adaptive_pixel_supersample_control] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Offers one item, holds it until accepted, then predicts its result.
    // Valid is only lowered in idle cycles, so back-to-back items keep it high.
    task automatic send_item(input apsc_pkg::op_t op, input logic [LUM_BITS-1:0] lum,
                             input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_luminance   <= lum;
        s_last_sample <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        step_pixel_walk(op, lum, last);
        if (op != apsc_pkg::OP_RESERVED)
            items_sent++;
    endtask

    // Sender pauses until every predicted result has been taken, plus a few
    // cycles for items still in flight that produce no result.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [apsc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_BITS:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            apsc_pkg::CFG_X_START:  win_x_start  = data;
            apsc_pkg::CFG_X_END:    win_x_end    = data;
            apsc_pkg::CFG_Y_START:  win_y_start  = data;
            apsc_pkg::CFG_Y_END:    win_y_end    = data;
            apsc_pkg::CFG_MIN_LOG2: win_min_log2 = data[2:0];
            apsc_pkg::CFG_MAX_LOG2: win_max_log2 = data[2:0];
            default: ;
        endcase
    endtask

    // Writes the whole register set once the block is idle. The log2 writes
    // sometimes carry junk above bit 2, which the block must drop.
    task automatic load_window(input logic [COORD_BITS:0] xs, input logic [COORD_BITS:0] xe,
                               input logic [COORD_BITS:0] ys, input logic [COORD_BITS:0] ye,
                               input logic [2:0] mn, input logic [2:0] mx);
        logic [9:0] junk_mn, junk_mx;
        junk_mn = $urandom_range(1) ? 10'($urandom) : '0;
        junk_mx = $urandom_range(1) ? 10'($urandom) : '0;
        drain_results();
        write_reg(apsc_pkg::CFG_X_START, xs);
        write_reg(apsc_pkg::CFG_X_END, xe);
        write_reg(apsc_pkg::CFG_Y_START, ys);
        write_reg(apsc_pkg::CFG_Y_END, ye);
        write_reg(apsc_pkg::CFG_MIN_LOG2, {junk_mn, mn});
        write_reg(apsc_pkg::CFG_MAX_LOG2, {junk_mx, mx});
        cfg_wr_en <= 1'b0;
    endtask

    // One pixel: a request, then its samples with the last one flagged.
    // About one in ten calls sends a noise item instead, and a few batches
    // are broken (wrong length, no last flag) or long enough to saturate
    // the running sum.
    task automatic run_pixel_batch();
        int                  n, k, mode, roll, odd_one, i;
        logic [LUM_BITS-1:0] base, lum;
        logic                drop_last;
        if ($urandom_range(99) < 10) begin
            send_item(apsc_pkg::op_t'($urandom_range(3)), LUM_BITS'($urandom),
                      1'($urandom));
            return;
        end
        send_item(apsc_pkg::OP_REQUEST, LUM_BITS'($urandom), 1'($urandom));
        n = batch_count_seen;
        if (n == 0) begin
            // Window done: restart, or keep judging pixels past the end
            if ($urandom_range(1)) begin
                send_item(apsc_pkg::OP_RESTART, LUM_BITS'($urandom), 1'($urandom));
                return;
            end
            n = $urandom_range(1, 4);
        end
        roll = $urandom_range(99);
        if (roll < 3)
            k = 65 + $urandom_range(15);
        else if (roll < 15)
            k = $urandom_range(1, n + 2);
        else
            k = n;
        mode      = (roll < 3) ? 5 : $urandom_range(4);
        base      = LUM_BITS'($urandom);
        odd_one   = $urandom_range(k - 1);
        drop_last = ($urandom_range(99) < 5);
        for (i = 0; i < k; i++) begin
            case (mode)
                0: lum = base + LUM_BITS'($urandom_range(31));          // nearly flat
                1: lum = LUM_BITS'($urandom);                           // anything
                2: lum = (i == odd_one) ? LUM_BITS'($urandom) : base;   // one outlier
                3: lum = $urandom_range(3) == 0 ? LUM_BITS'($urandom_range(3)) : '0;
                4: lum = (i % 2 == 0) ? LUM_BITS'(base % 21000)         // near the threshold
                                      : LUM_BITS'(3 * (base % 21000) + $urandom_range(2));
                default: lum = 16'hFF00 | LUM_BITS'($urandom_range(255));
            endcase
            send_item(apsc_pkg::OP_SAMPLE, lum, (i == k - 1) && !drop_last);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset window is empty (y_end = 0 = row), so a request finds it finished;
    // a verdict still advances; op 3 does nothing.
    task automatic test_reset_state();
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_RESERVED, 16'hFFFF, 1'b1);
        send_item(apsc_pkg::OP_SAMPLE, 16'h0000, 1'b1);    // zero sum never supersamples
        send_item(apsc_pkg::OP_REQUEST, 16'hFFFF, 1'b1);
    endtask

    // Contrast boundary with N = 2: samples a and 3a sit exactly on the limit,
    // 3a + 1 goes over. Then the supersample batch, end of window, and a batch
    // shorter than N.
    task automatic test_contrast_rules();
        load_window(13'd0, 13'd2, 13'd0, 13'd1, 3'd1, 3'd2);
        send_item(apsc_pkg::OP_RESTART, 16'h1234, 1'b1);
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_SAMPLE, 16'd100, 1'b0);
        send_item(apsc_pkg::OP_SAMPLE, 16'd300, 1'b1);     // equal: accepted
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_SAMPLE, 16'd100, 1'b0);
        send_item(apsc_pkg::OP_SAMPLE, 16'd301, 1'b1);     // over: supersample
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);   // max count
        send_item(apsc_pkg::OP_SAMPLE, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_SAMPLE, 16'hFFFF, 1'b1);    // after supersampling: no test
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);   // window finished
        send_item(apsc_pkg::OP_SAMPLE, 16'hFFFF, 1'b1);    // verdict past the end
        send_item(apsc_pkg::OP_RESTART, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_SAMPLE, 16'hFFFF, 1'b1);    // one sample while N = 2
        send_item(apsc_pkg::OP_RESERVED, 16'h0000, 1'b0);
    endtask

    // log2 registers beyond the maximum clamp to 64 samples
    task automatic test_count_saturation();
        load_window(13'd0, 13'd3, 13'd0, 13'd2, 3'd7, 3'd7);
        send_item(apsc_pkg::OP_RESTART, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_SAMPLE, 16'h0000, 1'b1);
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);
    endtask

    // Window at the top of the 13-bit range: the column count wraps to zero, and the row wraps to zero past the end
    task automatic test_window_wrap();
        load_window(13'h1FFF, 13'h0000, 13'h1FFE, 13'h1FFF, 3'd0, 3'd6);
        send_item(apsc_pkg::OP_RESTART, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_SAMPLE, 16'h1234, 1'b1);
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);
        send_item(apsc_pkg::OP_SAMPLE, 16'h8000, 1'b1);
        send_item(apsc_pkg::OP_REQUEST, 16'h0000, 1'b0);
    endtask

    // Receiver holds off while items keep coming, so the block fills and
    // stalls its input; then the sender waits for every result; then a
    // stretch with no idling on either side.
    task automatic test_output_backpressure();
        load_window(13'd5, 13'd9, 13'd100, 13'd104, 3'd1, 3'd3);
        send_item(apsc_pkg::OP_RESTART, 16'h0000, 1'b0);
        rx_hold_req = HOLD_CYCLES;
        repeat (25) run_pixel_batch();
        drain_results();
        idle_pct = 0;
        repeat (60) run_pixel_batch();
        idle_pct = NORMAL_IDLE;
    endtask

    // Random windows until the item budget is spent. Coordinates lean to
    // the extremes now and then; most windows are a few pixels wide so
    // they finish often. Large sample counts are kept rare.
    task automatic test_random_windows();
        logic [COORD_BITS:0] xs, xe, ys, ye;
        logic [2:0]          mn, mx;
        int                  r;
        while (items_sent < ITEM_TARGET) begin
            r  = $urandom_range(9);
            xs = (r == 0) ? 13'h0000 : (r == 1) ? 13'h1FFF : (r == 2) ? 13'h1000
                                     : 13'($urandom);
            xe = ($urandom_range(19) == 0) ? 13'($urandom) : xs + 13'($urandom_range(1, 4));
            r  = $urandom_range(9);
            ys = (r == 0) ? 13'h0000 : (r == 1) ? 13'h1FFF : (r == 2) ? 13'h1000
                                     : 13'($urandom);
            ye = ($urandom_range(19) == 0) ? 13'($urandom) : ys + 13'($urandom_range(0, 3));
            mn = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
            mx = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
            load_window(xs, xe, ys, ye, mn, mx);
            if ($urandom_range(9) < 8)
                send_item(apsc_pkg::OP_RESTART, LUM_BITS'($urandom), 1'($urandom));
            repeat ($urandom_range(10, 40)) run_pixel_batch();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_operation   = '0;
        s_luminance   = '0;
        s_last_sample = 1'b0;
        m_ready       = 1'b0;
        reset_walk();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_contrast_rules();
        test_count_saturation();
        test_window_wrap();
        test_output_backpressure();
        test_random_windows();

        // All items sent: wait out the results, then the pipeline tail
        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("[adaptive_pixel_supersample_control] OK");
        else
            $display("[adaptive_pixel_supersample_control] ERROR");
        $finish;
    end

endmodule
